// ----- rtl/core/afc_pkg.sv -----
// Package for the box frustum cull unit: sizes, plane layout and stage types.
package afc_pkg;

	localparam int COORD_BITS = 16;
	localparam int IN_BITS    = 16;
	localparam int COMP_BITS  = 16;
	localparam int FRAC_BITS  = 14;
	localparam int NUM_PLANES = 6;
	localparam int NUM_AXES   = 3;
	localparam int CFG_BITS   = 64;
	localparam int IDX_BITS   = $clog2(NUM_PLANES);
	localparam int PROD_BITS  = COORD_BITS + COMP_BITS;
	// three products plus the scaled offset, with headroom
	localparam int SUM_BITS   = PROD_BITS + 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COMP_BITS-1:0]  comp_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [SUM_BITS-1:0]   sum_t;

	// bits 63:48 w, 47:32 nz, 31:16 ny, 15:0 nx
	typedef struct packed {
		comp_t w;
		comp_t nz;
		comp_t ny;
		comp_t nx;
	} plane_t;

	typedef plane_t planes_t [NUM_PLANES];
	typedef coord_t box_t [NUM_AXES];
	typedef coord_t corners_t [NUM_PLANES][NUM_AXES];
	typedef prod_t  prods_t [NUM_PLANES][NUM_AXES];

	// sideband that travels with each transaction down the pipe
	typedef struct packed {
		logic valid;
		logic last;
	} stage_ctl_t;

	function automatic comp_t plane_comp(input plane_t pl, input int axis);
		comp_t c;
		c = pl.nx;
		if (axis == 1) c = pl.ny;
		if (axis == 2) c = pl.nz;
		return c;
	endfunction

endpackage

// ----- rtl/core/aabb_frustum_cull_unit.sv -----
// Top level of the box frustum cull unit: four-stage positive-vertex plane test.
//
// channel   direction  handshake           payload
// box in    in         start & !busy       box_min_x/y/z, box_max_x/y/z, last_box
// result    out        done (one cycle)    visible, last_result
// config    in         cfg_wr_en           cfg_index, cfg_data
//
// One box per cycle; the result strobes once the box has passed the corner select,
// multiply, sum and sign, and plane AND registers.
// busy is always low: the pipe never stalls, since results cannot be held off.
// Reset clears the valid bits and zeroes all planes, so every box reads visible.
// Planes are read live by stages 1 to 3; write them only when the pipe is empty.
module aabb_frustum_cull_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [afc_pkg::IN_BITS-1:0] box_min_x,
	input  logic signed [afc_pkg::IN_BITS-1:0] box_min_y,
	input  logic signed [afc_pkg::IN_BITS-1:0] box_min_z,
	input  logic signed [afc_pkg::IN_BITS-1:0] box_max_x,
	input  logic signed [afc_pkg::IN_BITS-1:0] box_max_y,
	input  logic signed [afc_pkg::IN_BITS-1:0] box_max_z,
	input  logic                          last_box,
	output logic                          done,
	output logic                          visible,
	output logic                          last_result,
	input  logic                          cfg_wr_en,
	input  logic [afc_pkg::IDX_BITS-1:0]  cfg_index,
	input  logic [afc_pkg::CFG_BITS-1:0]  cfg_data
);

	afc_pkg::planes_t               planes;
	afc_pkg::stage_ctl_t            ctl_in;
	afc_pkg::stage_ctl_t            ctl_s1;
	afc_pkg::stage_ctl_t            ctl_s3;
	afc_pkg::box_t                  box_min;
	afc_pkg::box_t                  box_max;
	afc_pkg::corners_t              corner_s1;
	logic [afc_pkg::NUM_PLANES-1:0] pass_s3;

	assign busy = 1'b0;
	assign ctl_in.valid = start && !busy;
	assign ctl_in.last  = last_box;

	// bits above the coordinate width are ignored
	assign box_min[0] = box_min_x[afc_pkg::COORD_BITS-1:0];
	assign box_min[1] = box_min_y[afc_pkg::COORD_BITS-1:0];
	assign box_min[2] = box_min_z[afc_pkg::COORD_BITS-1:0];
	assign box_max[0] = box_max_x[afc_pkg::COORD_BITS-1:0];
	assign box_max[1] = box_max_y[afc_pkg::COORD_BITS-1:0];
	assign box_max[2] = box_max_z[afc_pkg::COORD_BITS-1:0];

	afc_plane_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes)
	);

	afc_corner_sel u_sel (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_in),
		.box_min   (box_min),
		.box_max   (box_max),
		.planes    (planes),
		.ctl_s1    (ctl_s1),
		.corner_s1 (corner_s1)
	);

	afc_plane_dot u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.corner_s1 (corner_s1),
		.planes    (planes),
		.ctl_s3    (ctl_s3),
		.pass_s3   (pass_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		visible     <= &pass_s3;
		last_result <= ctl_s3.last;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted transaction produced no result strobe");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result strobe without an accepted transaction");

	a_last_tag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_result == $past(last_box, 4)))
		else $error("last_result does not match its transaction");

	a_all_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s3.valid && (&pass_s3)) |=> (done && visible))
		else $error("box passing every plane reported culled");

endmodule

// ----- rtl/core/afc_plane_regs.sv -----
// Six plane configuration registers with a plain write port.
module afc_plane_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [afc_pkg::IDX_BITS-1:0]  cfg_index,
	input  logic [afc_pkg::CFG_BITS-1:0]  cfg_data,
	output afc_pkg::planes_t              planes
);

	afc_pkg::planes_t planes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
				planes_q[p] <= '0;
			end
		end else if (cfg_wr_en) begin
			// indexes past the last plane decode to nothing
			for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
				if (cfg_index == afc_pkg::IDX_BITS'(p)) begin
					planes_q[p] <= afc_pkg::plane_t'(cfg_data);
				end
			end
		end
	end

	assign planes = planes_q;

endmodule

// ----- rtl/core/afc_corner_sel.sv -----
// Stage 1: picks the positive vertex of the box for every plane.
module afc_corner_sel (
	input  logic                 clk,
	input  logic                 arst_n,
	input  afc_pkg::stage_ctl_t  ctl_in,
	input  afc_pkg::box_t        box_min,
	input  afc_pkg::box_t        box_max,
	input  afc_pkg::planes_t     planes,
	output afc_pkg::stage_ctl_t  ctl_s1,
	output afc_pkg::corners_t    corner_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	// negative normal component takes the minimum; zero counts as non-negative
	always_ff @(posedge clk) begin
		for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
			for (int a = 0; a < afc_pkg::NUM_AXES; a++) begin
				corner_s1[p][a] <= (afc_pkg::plane_comp(planes[p], a) < 0)
					? box_min[a] : box_max[a];
			end
		end
	end

endmodule

// ----- rtl/core/afc_plane_dot.sv -----
// Stages 2 and 3: per-plane products, then sum with scaled offset and sign test.
module afc_plane_dot (
	input  logic                          clk,
	input  logic                          arst_n,
	input  afc_pkg::stage_ctl_t           ctl_s1,
	input  afc_pkg::corners_t             corner_s1,
	input  afc_pkg::planes_t              planes,
	output afc_pkg::stage_ctl_t           ctl_s3,
	output logic [afc_pkg::NUM_PLANES-1:0] pass_s3
);

	afc_pkg::stage_ctl_t ctl_s2;
	afc_pkg::prods_t     prod_s2;
	afc_pkg::sum_t       plane_sum [afc_pkg::NUM_PLANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
			for (int a = 0; a < afc_pkg::NUM_AXES; a++) begin
				prod_s2[p][a] <= afc_pkg::PROD_BITS'(afc_pkg::plane_comp(planes[p], a))
					* afc_pkg::PROD_BITS'(corner_s1[p][a]);
			end
		end
	end

	always_comb begin
		for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
			plane_sum[p] = afc_pkg::SUM_BITS'(prod_s2[p][0])
				+ afc_pkg::SUM_BITS'(prod_s2[p][1])
				+ afc_pkg::SUM_BITS'(prod_s2[p][2])
				+ (afc_pkg::SUM_BITS'(planes[p].w) <<< afc_pkg::FRAC_BITS);
		end
	end

	// a sum of exactly zero lies on the plane and passes
	always_ff @(posedge clk) begin
		for (int p = 0; p < afc_pkg::NUM_PLANES; p++) begin
			pass_s3[p] <= !plane_sum[p][afc_pkg::SUM_BITS-1];
		end
	end

endmodule

// ----- tb/tb_aabb_frustum_cull_unit.sv -----
`timescale 1ns / 1ps
// Testbench for the box frustum cull unit: plane programming, box stream and result check.
module tb_aabb_frustum_cull_unit;
	import afc_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 6;
	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_LIMIT   = 500;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_BOXES  = 150;
	localparam int ONE_Q14      = 1 << FRAC_BITS;

	typedef enum int {PL_LEFT, PL_RIGHT, PL_BOTTOM, PL_TOP, PL_NEAR, PL_FAR} plane_idx_e;

	typedef struct packed {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
		logic   last;
	} box_txn_t;

	typedef struct packed {
		logic visible;
		logic last;
	} cull_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	coord_t              box_min_x = '0;
	coord_t              box_min_y = '0;
	coord_t              box_min_z = '0;
	coord_t              box_max_x = '0;
	coord_t              box_max_y = '0;
	coord_t              box_max_z = '0;
	logic                last_box = 1'b0;
	logic                done;
	logic                visible;
	logic                last_result;
	logic                cfg_wr_en = 1'b0;
	logic [IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;

	box_txn_t     pending_boxes[$];
	cull_result_t expected_results[$];
	plane_t       cull_planes [NUM_PLANES];
	plane_t       next_planes [NUM_PLANES];
	int           error_count = 0;
	int           idle_cycles = 0;
	int           burst_left = 0;
	int           gap_left = 0;
	bit           steady_stream = 1'b0;

	aabb_frustum_cull_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.box_min_x   (box_min_x),
		.box_min_y   (box_min_y),
		.box_min_z   (box_min_z),
		.box_max_x   (box_max_x),
		.box_max_y   (box_max_y),
		.box_max_z   (box_max_z),
		.last_box    (last_box),
		.done        (done),
		.visible     (visible),
		.last_result (last_result),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// positive vertex: max corner where the component is >= 0, min corner otherwise
	function automatic longint corner_term(input comp_t n, input coord_t lo, input coord_t hi);
		coord_t p;
		p = (n >= 0) ? hi : lo;
		return longint'(n) * longint'(p);
	endfunction

	function automatic logic predict_visible(input box_txn_t b);
		longint acc;
		logic   vis;
		vis = 1'b1;
		for (int i = 0; i < NUM_PLANES; i++) begin
			acc = longint'(cull_planes[i].w) * ONE_Q14;
			acc += corner_term(cull_planes[i].nx, b.min_x, b.max_x);
			acc += corner_term(cull_planes[i].ny, b.min_y, b.max_y);
			acc += corner_term(cull_planes[i].nz, b.min_z, b.max_z);
			if (acc < 0) vis = 1'b0;
		end
		return vis;
	endfunction

	function automatic plane_t make_plane(input int nx, input int ny, input int nz, input int w);
		plane_t pl;
		pl.nx = comp_t'(nx);
		pl.ny = comp_t'(ny);
		pl.nz = comp_t'(nz);
		pl.w  = comp_t'(w);
		return pl;
	endfunction

	function automatic plane_t random_plane();
		plane_t pl;
		case ($urandom_range(0, 5))
			0: pl = '0;
			1: pl = {$urandom, $urandom};
			default: pl = make_plane(int'($urandom_range(0, 2 * ONE_Q14)) - ONE_Q14,
			                         int'($urandom_range(0, 2 * ONE_Q14)) - ONE_Q14,
			                         int'($urandom_range(0, 2 * ONE_Q14)) - ONE_Q14,
			                         int'($urandom_range(0, 12000)) - 2000);
		endcase
		return pl;
	endfunction

	task automatic queue_box(input int lx, input int ly, input int lz,
	                         input int hx, input int hy, input int hz, input logic last);
		box_txn_t b;
		b.min_x = coord_t'(lx);
		b.min_y = coord_t'(ly);
		b.min_z = coord_t'(lz);
		b.max_x = coord_t'(hx);
		b.max_y = coord_t'(hy);
		b.max_z = coord_t'(hz);
		b.last  = last;
		pending_boxes.push_back(b);
	endtask

	task automatic queue_random_box();
		int   c [NUM_AXES];
		int   h [NUM_AXES];
		int   mode;
		logic last;
		mode = $urandom_range(0, 7);
		last = ($urandom_range(0, 7) == 0);
		for (int a = 0; a < NUM_AXES; a++) begin
			c[a] = int'($urandom_range(0, 6000)) - 3000;
			h[a] = $urandom_range(0, 1500);
		end
		if (mode == 6)
			queue_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, last);
		else if (mode == 7)
			// inverted box: min at or above max
			queue_box(c[0] + h[0], c[1] + h[1], c[2] + h[2],
			          c[0] - h[0], c[1] - h[1], c[2] - h[2], last);
		else
			queue_box(c[0] - h[0], c[1] - h[1], c[2] - h[2],
			          c[0] + h[0], c[1] + h[1], c[2] + h[2], last);
	endtask

	// wait for the pipe to empty before touching the planes
	task automatic drain_pipe();
		while (pending_boxes.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// writes all six planes, then the unused indexes, which must be ignored
	task automatic program_planes();
		for (int i = 0; i < (1 << IDX_BITS); i++) begin
			@(negedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= i[IDX_BITS-1:0];
			if (i < NUM_PLANES) begin
				cfg_data       <= next_planes[i];
				cull_planes[i] = next_planes[i];
			end else begin
				cfg_data <= {$urandom, $urandom};
			end
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// driver: bursts of random length separated by random gaps, or a steady stream when steady_stream is set
	always @(negedge clk) begin
		if (!arst_n || pending_boxes.size() == 0) begin
			start <= 1'b0;
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left--;
		end else begin
			start     <= 1'b1;
			box_min_x <= pending_boxes[0].min_x;
			box_min_y <= pending_boxes[0].min_y;
			box_min_z <= pending_boxes[0].min_z;
			box_max_x <= pending_boxes[0].max_x;
			box_max_y <= pending_boxes[0].max_y;
			box_max_z <= pending_boxes[0].max_z;
			last_box  <= pending_boxes[0].last;
			if (burst_left > 0) begin
				burst_left--;
			end else if (!steady_stream) begin
				burst_left = $urandom_range(0, 24);
				gap_left   = $urandom_range(1, 6);
			end
		end
	end

	// monitor: predicts on each accepted box, checks each strobed result
	always @(posedge clk) begin
		box_txn_t     b;
		cull_result_t want;
		if (arst_n && start && !busy) begin
			b = {box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, last_box};
			want.visible = predict_visible(b);
			want.last    = last_box;
			expected_results.push_back(want);
			void'(pending_boxes.pop_front());
		end
		if (arst_n && $isunknown(done)) begin
			$display("%0t: done unknown, expected 0 or 1, actual %b", $time, done);
			error_count++;
		end else if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual visible %b last %b",
				         $time, visible, last_result);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (visible !== want.visible) begin
					$display("%0t: visible mismatch, expected %b actual %b",
					         $time, want.visible, visible);
					error_count++;
				end
				if (last_result !== want.last) begin
					$display("%0t: last_result mismatch, expected %b actual %b",
					         $time, want.last, last_result);
					error_count++;
				end
			end
		end
		if ((start && !busy) || done || cfg_wr_en || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
		$display("FAIL aabb_frustum_cull_unit");
		$finish;
	end

	initial begin
		for (int i = 0; i < NUM_PLANES; i++) cull_planes[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// planes after reset are all zero: everything visible
		queue_box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b0);
		queue_box(0, 0, 0, 0, 0, 0, 1'b1);
		queue_box(32767, 32767, 32767, -32768, -32768, -32768, 1'b0);
		queue_box(-1, 1, -1, 1, -1, 1, 1'b1);
		drain_pipe();

		// axis-aligned frustum spanning -1000..1000 on each axis
		next_planes[PL_LEFT]   = make_plane(ONE_Q14, 0, 0, 1000);
		next_planes[PL_RIGHT]  = make_plane(-ONE_Q14, 0, 0, 1000);
		next_planes[PL_BOTTOM] = make_plane(0, ONE_Q14, 0, 1000);
		next_planes[PL_TOP]    = make_plane(0, -ONE_Q14, 0, 1000);
		next_planes[PL_NEAR]   = make_plane(0, 0, ONE_Q14, 1000);
		next_planes[PL_FAR]    = make_plane(0, 0, -ONE_Q14, 1000);
		program_planes();
		queue_box(-10, -10, -10, 10, 10, 10, 1'b0);
		queue_box(-2000, 0, 0, -1000, 5, 5, 1'b0);     // touches left plane, sum zero
		queue_box(-2000, 0, 0, -1001, 5, 5, 1'b1);     // just outside left
		queue_box(1000, 0, 0, 2000, 5, 5, 1'b0);       // touches right plane
		queue_box(1001, 0, 0, 2000, 5, 5, 1'b0);       // just outside right
		queue_box(0, -3000, 0, 5, -1001, 5, 1'b0);     // below bottom
		queue_box(0, 1001, 0, 5, 3000, 5, 1'b0);       // above top
		queue_box(0, 0, -3000, 5, 5, -1001, 1'b0);     // in front of near
		queue_box(0, 0, 1001, 5, 5, 3000, 1'b0);       // beyond far
		queue_box(-5000, -5000, -5000, 5000, 5000, 5000, 1'b0);
		queue_box(5000, 0, 0, -5000, 5, 5, 1'b1);      // inverted box straddling
		drain_pipe();

		// extreme planes
		for (int i = 0; i < NUM_PLANES; i++) next_planes[i] = {4{16'h7fff}};
		program_planes();
		queue_box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b0);
		queue_box(32767, 32767, 32767, -32768, -32768, -32768, 1'b1);
		drain_pipe();
		for (int i = 0; i < NUM_PLANES; i++) next_planes[i] = {4{16'h8000}};
		program_planes();
		queue_box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b0);
		queue_box(32767, 32767, 32767, -32768, -32768, -32768, 1'b1);
		queue_box(0, 0, 0, 0, 0, 0, 1'b0);
		drain_pipe();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			for (int i = 0; i < NUM_PLANES; i++) next_planes[i] = random_plane();
			if (ph == RAND_PHASES - 1)
				for (int i = 0; i < NUM_PLANES; i++) next_planes[i] = {$urandom, $urandom};
			program_planes();
			steady_stream = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_BOXES; n++) queue_random_box();
			drain_pipe();
		end

		if (error_count == 0)
			$display("PASS aabb_frustum_cull_unit");
		else
			$display("FAIL aabb_frustum_cull_unit");
		$finish;
	end

endmodule
